[rtl/core/sh128_pkg.sv]
// Shared types, constants and round functions of the short 128-bit hash.
`timescale 1ns / 1ps

package sh128_pkg;

  localparam logic [63:0] MAGIC = 64'hdeadbeefdeadbeef;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef logic [63:0] lane_t;
  typedef logic [3:0][63:0] lanes_t;

  typedef struct packed {
    logic  first;
    logic  do_mix;
    logic  fin;
    lane_t x0;
    lane_t x1;
    lane_t y0;
    lane_t y1;
    lane_t tc;
    lane_t td;
  } op_t;

  function automatic lane_t rotl(lane_t x, logic [5:0] amt);
    return (x << amt) | (x >> (7'd64 - {1'b0, amt}));
  endfunction

  function automatic logic [5:0] mix_rot(logic [3:0] r);
    logic [5:0] amt;
    case (r)
      4'd0:    amt = 6'd50;
      4'd1:    amt = 6'd52;
      4'd2:    amt = 6'd30;
      4'd3:    amt = 6'd41;
      4'd4:    amt = 6'd54;
      4'd5:    amt = 6'd48;
      4'd6:    amt = 6'd38;
      4'd7:    amt = 6'd37;
      4'd8:    amt = 6'd62;
      4'd9:    amt = 6'd34;
      4'd10:   amt = 6'd5;
      4'd11:   amt = 6'd36;
      default: amt = 6'd1;
    endcase
    return amt;
  endfunction

  function automatic logic [5:0] end_rot(logic [3:0] r);
    logic [5:0] amt;
    case (r)
      4'd0:    amt = 6'd15;
      4'd1:    amt = 6'd52;
      4'd2:    amt = 6'd26;
      4'd3:    amt = 6'd51;
      4'd4:    amt = 6'd28;
      4'd5:    amt = 6'd9;
      4'd6:    amt = 6'd47;
      4'd7:    amt = 6'd54;
      4'd8:    amt = 6'd32;
      4'd9:    amt = 6'd25;
      4'd10:   amt = 6'd63;
      default: amt = 6'd1;
    endcase
    return amt;
  endfunction

  function automatic lanes_t mix_round(lanes_t h, logic [3:0] r);
    lanes_t     o;
    logic [1:0] i_p;
    logic [1:0] i_q;
    logic [1:0] i_s;
    o   = h;
    i_s = r[1:0];
    i_p = r[1:0] + 2'd2;
    i_q = r[1:0] + 2'd3;
    o[i_p] = rotl(o[i_p], mix_rot(r)) + o[i_q];
    o[i_s] = o[i_s] ^ o[i_p];
    return o;
  endfunction

  function automatic lanes_t end_round(lanes_t h, logic [3:0] r);
    lanes_t     o;
    logic [1:0] i_p;
    logic [1:0] i_q;
    o   = h;
    i_p = r[1:0] + 2'd2;
    i_q = r[1:0] + 2'd3;
    o[i_q] = o[i_q] ^ o[i_p];
    o[i_p] = rotl(o[i_p], end_rot(r));
    o[i_q] = o[i_q] + o[i_p];
    return o;
  endfunction

  // Three rounds per step: step s covers rounds 3s .. 3s+2.
  function automatic lanes_t mix_step(lanes_t h, logic [1:0] step);
    lanes_t     o;
    logic [3:0] r0;
    o  = h;
    r0 = {1'b0, step, 1'b0} + {2'b00, step};
    for (int j = 0; j < 3; j++) begin
      o = mix_round(o, r0 + 4'(j));
    end
    return o;
  endfunction

  function automatic lanes_t end_step(lanes_t h, logic [1:0] step);
    lanes_t     o;
    logic [3:0] r0;
    o  = h;
    r0 = {1'b0, step, 1'b0} + {2'b00, step};
    for (int j = 0; j < 3; j++) begin
      if ((r0 + 4'(j)) < 4'd11) begin
        o = end_round(o, r0 + 4'(j));
      end
    end
    return o;
  endfunction

endpackage

[rtl/core/sh128_front.sv]
// Front end: takes message words, buffers pending words, builds lane operations.
`timescale 1ns / 1ps

module sh128_front import sh128_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last,
  output logic        push_valid,
  input  logic        push_ready,
  output op_t         push_op
);

  lane_t       pend [3];
  logic [7:0]  len;
  logic        started;

  logic        accept;
  logic [1:0]  k;
  logic [3:0]  bc;
  lane_t       mask;
  lane_t       wm;
  lane_t       buf0, buf1, buf2, buf3;
  logic [7:0]  total;
  logic        half;
  logic        tail_empty;
  lane_t       t0, t1;
  lane_t       tc, tdv, td;
  logic        full_block;

  assign k        = len[4:3];
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    bc = (byte_count > 4'd8) ? 4'd8 : byte_count;
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = (4'(i) < bc) ? 8'hff : 8'h00;
    end
    wm = data_word & mask;

    buf0 = (k == 2'd0) ? wm : pend[0];
    buf1 = (k == 2'd1) ? wm : ((k > 2'd1) ? pend[1] : '0);
    buf2 = (k == 2'd2) ? wm : ((k > 2'd2) ? pend[2] : '0);
    buf3 = (k == 2'd3) ? wm : '0;

    total      = len + {4'b0000, bc};
    half       = total[4];
    tail_empty = (total[3:0] == 4'd0);
    t0         = half ? buf2 : buf0;
    t1         = half ? buf3 : buf1;
    tc         = tail_empty ? MAGIC : t0;
    tdv        = tail_empty ? MAGIC : t1;
    td         = {tdv[63:56] + total, tdv[55:0]};
    full_block = (k == 2'd3) && (!last || (bc == 4'd8));

    push_valid     = in_valid && (last || (k == 2'd3));
    push_op.first  = !started;
    push_op.fin    = last;
    push_op.tc     = tc;
    push_op.td     = td;
    if (full_block) begin
      push_op.do_mix = 1'b1;
      push_op.x0     = pend[0];
      push_op.x1     = pend[1];
      push_op.y0     = pend[2];
      push_op.y1     = data_word;
    end else if (half) begin
      push_op.do_mix = 1'b1;
      push_op.x0     = buf0;
      push_op.x1     = buf1;
      push_op.y0     = '0;
      push_op.y1     = '0;
    end else begin
      push_op.do_mix = 1'b0;
      push_op.x0     = tc;
      push_op.x1     = td;
      push_op.y0     = '0;
      push_op.y1     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      started <= 1'b0;
    end else if (accept) begin
      if (last) begin
        len     <= '0;
        started <= 1'b0;
      end else begin
        len <= len + 8'd8;
        if (k == 2'd3) begin
          started <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last && (k != 2'd3)) begin
      pend[k] <= data_word;
    end
  end

endmodule

[rtl/core/sh128_queue.sv]
// Short queue of lane operations between the front end and the mixer.
`timescale 1ns / 1ps

module sh128_queue import sh128_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  op_t             slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != Q_CW'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [Q_AW-1:0] ptr_inc(logic [Q_AW-1:0] p);
    return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

[rtl/core/sh128_back.sv]
// Back end: holds the four lanes, runs block mix, tail fold and end mix.
`timescale 1ns / 1ps

module sh128_back import sh128_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lane_t       seed,
  input  logic        op_valid,
  output logic        op_ready,
  input  op_t         op,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_low,
  output logic [63:0] hash_high
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MIX  = 4'b0010,
    S_TAIL = 4'b0100,
    S_END  = 4'b1000
  } bstate_t;

  bstate_t    state, state_next;
  logic [1:0] step, step_next;
  lanes_t     h, h_next;
  lane_t      pa, pa_next;
  lane_t      pb, pb_next;
  op_t        cur;
  logic       load_out;
  logic       pop;

  assign op_ready = (state == S_IDLE);
  assign pop      = op_valid && op_ready;

  always_comb begin
    state_next = state;
    step_next  = step;
    h_next     = h;
    pa_next    = pa;
    pb_next    = pb;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (op_valid) begin
          if (op.first) begin
            h_next = {MAGIC + op.x1, MAGIC + op.x0, seed, seed};
          end else begin
            h_next = {h[3] + op.x1, h[2] + op.x0, h[1] + pb, h[0] + pa};
          end
          step_next  = 2'd0;
          state_next = op.do_mix ? S_MIX : S_END;
        end
      end
      S_MIX: begin
        h_next    = mix_step(h, step);
        step_next = step + 2'd1;
        if (step == 2'd3) begin
          if (cur.fin) begin
            state_next = S_TAIL;
          end else begin
            pa_next    = cur.y0;
            pb_next    = cur.y1;
            state_next = S_IDLE;
          end
        end
      end
      S_TAIL: begin
        h_next     = {h[3] + cur.td, h[2] + cur.tc, h[1] + cur.y1, h[0] + cur.y0};
        step_next  = 2'd0;
        state_next = S_END;
      end
      S_END: begin
        if ((step != 2'd3) || !out_valid || out_ready) begin
          h_next    = end_step(h, step);
          step_next = step + 2'd1;
          if (step == 2'd3) begin
            load_out   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    h  <= h_next;
    pa <= pa_next;
    pb <= pb_next;
    if (pop) begin
      cur <= op;
    end
    if (load_out) begin
      hash_low  <= h_next[0];
      hash_high <= h_next[1];
    end
  end

`ifndef SYNTHESIS
  a_mix_needs_op: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIX) |-> cur.do_mix)
    else $error("mix running for an operation without a block");

  a_tail_only_final: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAIL) |-> (cur.fin && cur.do_mix))
    else $error("tail fold outside a final half-block operation");

  a_no_mix_is_final: assert property (@(posedge clk) disable iff (rst)
    pop && !op.do_mix |-> op.fin)
    else $error("front end issued an operation with no work");

  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_END && step == 2'd3))
    else $error("result loaded outside the last end-mix step");
`endif

endmodule

[rtl/core/short_hash128_stream_unit.sv]
// Streaming 128-bit short-message hash unit.
//
// Input channel (in_valid/in_ready): one little-endian 64-bit word per
// accept, data_word with byte_count valid bytes and last on the final word.
// Words without last always count as eight bytes.
// Output channel (out_valid/out_ready): one hash (hash_low, hash_high) per
// message, registered, held until taken.
// Seed channel (seed_valid/seed_ready): always ready; write only while idle,
// the mixer loads the seed into the lanes at the first operation of a message.
// Throughput: the front end takes one word per cycle while its two-entry
// operation queue has room. Each 32-byte block costs the mixer an add and
// the block mix, three rounds per step; the mixer takes a new operation
// only once done with the last, while the front end fills the queue.
// Message end costs an add and the end mix, or an add, the block mix, a
// tail fold and the end mix when the last block holds 16 bytes or more.
// Reset clears the seed to zero and empties the queue and result register.
// A stalled receiver holds the next message's end mix at its last step;
// blocks before that keep mixing, but later operations wait.
`timescale 1ns / 1ps

module short_hash128_stream_unit import sh128_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_valid,
  output logic        seed_ready,
  input  logic [63:0] seed_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_low,
  output logic [63:0] hash_high
);

  lane_t seed;
  logic  push_valid;
  logic  push_ready;
  op_t   push_op;
  logic  pop_valid;
  logic  pop_ready;
  op_t   pop_op;

  assign seed_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (seed_valid) begin
      seed <= seed_data;
    end
  end

  sh128_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  sh128_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  sh128_back u_back (
    .clk       (clk),
    .rst       (rst),
    .seed      (seed),
    .op_valid  (pop_valid),
    .op_ready  (pop_ready),
    .op        (pop_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hash_low  (hash_low),
    .hash_high (hash_high)
  );

endmodule

[sim/tb_short_hash128_stream_unit.sv]
// Self-checking testbench of the streaming 128-bit short-message hash unit.
`timescale 1ns / 1ps

module tb_short_hash128_stream_unit;

  localparam logic [63:0] HASH_MAGIC = 64'hdeadbeefdeadbeef;
  localparam logic [11:0][5:0] MIX_ROT = {6'd36, 6'd5, 6'd34, 6'd62, 6'd37, 6'd38,
                                          6'd48, 6'd54, 6'd41, 6'd30, 6'd52, 6'd50};
  localparam logic [10:0][5:0] END_ROT = {6'd63, 6'd25, 6'd32, 6'd54, 6'd47, 6'd9,
                                          6'd28, 6'd51, 6'd26, 6'd52, 6'd15};
  localparam int IDLE_PCT     = 17;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_WORDS  = 232;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nb;
    logic        fin;
  } word_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } digest_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        seed_valid = 1'b0;
  logic [63:0] seed_data  = '0;
  logic        in_valid   = 1'b0;
  logic [63:0] data_word  = '0;
  logic [3:0]  byte_count = '0;
  logic        last       = 1'b0;
  logic        out_ready  = 1'b0;
  logic        seed_ready;
  logic        in_ready;
  logic        out_valid;
  logic [63:0] hash_low;
  logic [63:0] hash_high;

  logic [63:0] seed_reg = '0;
  logic [63:0] lane [4];
  logic [63:0] pend [3];
  logic [7:0]  len_cnt  = '0;
  bit          in_msg   = 1'b0;
  digest_t     hash_q [$];
  int          mismatches  = 0;
  int          words_sent  = 0;
  int          idle_cycles = 0;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;
  bit          hold_go     = 1'b0;
  bit          steady      = 1'b0;

  word_t dir_tab [23] = '{
    '{64'h0000000000000000, 4'd0, 1'b1},
    '{64'hffffffffffffffff, 4'd8, 1'b1},
    '{64'hffffffffffffffff, 4'd15, 1'b1},
    '{64'hffffffffffffffff, 4'd9, 1'b1},
    '{64'hffffffffffffffff, 4'd3, 1'b1},
    '{64'h0123456789abcdef, 4'd3, 1'b0},
    '{64'hfedcba9876543210, 4'd0, 1'b1},
    '{64'h1111111111111111, 4'd8, 1'b0},
    '{64'h2222222222222222, 4'd8, 1'b0},
    '{64'h3333333333333333, 4'd8, 1'b0},
    '{64'h4444444444444444, 4'd8, 1'b1},
    '{64'h0000000000000000, 4'd8, 1'b0},
    '{64'hffffffffffffffff, 4'd8, 1'b1},
    '{64'h5555555555555555, 4'd8, 1'b0},
    '{64'haaaaaaaaaaaaaaaa, 4'd8, 1'b0},
    '{64'h8000000000000001, 4'd5, 1'b1},
    '{64'h0f0f0f0f0f0f0f0f, 4'd8, 1'b0},
    '{64'hf0f0f0f0f0f0f0f0, 4'd8, 1'b0},
    '{64'h00ff00ff00ff00ff, 4'd8, 1'b0},
    '{64'hff00ff00ff00ff00, 4'd8, 1'b0},
    '{64'hffffffffffffffff, 4'd0, 1'b1},
    '{64'hdeadbeefdeadbeef, 4'd8, 1'b0},
    '{64'hcafef00dcafef00d, 4'd7, 1'b1}
  };

  short_hash128_stream_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .seed_valid (seed_valid),
    .seed_ready (seed_ready),
    .seed_data  (seed_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_low   (hash_low),
    .hash_high  (hash_high)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] rot64(logic [63:0] x, logic [5:0] r);
    logic [127:0] d;
    d = {x, x} << r;
    return d[127:64];
  endfunction

  task automatic mix_lanes();
    int p;
    int q;
    int s;
    for (int i = 0; i < 12; i++) begin
      p = (i + 2) % 4;
      q = (i + 3) % 4;
      s = i % 4;
      lane[p] = rot64(lane[p], MIX_ROT[i]) + lane[q];
      lane[s] = lane[s] ^ lane[p];
    end
  endtask

  task automatic end_lanes();
    int p;
    int q;
    for (int i = 0; i < 11; i++) begin
      p = (i + 2) % 4;
      q = (i + 3) % 4;
      lane[q] = lane[q] ^ lane[p];
      lane[p] = rot64(lane[p], END_ROT[i]);
      lane[q] = lane[q] + lane[p];
    end
  endtask

  task automatic absorb_block(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                              logic [63:0] w3);
    lane[2] = lane[2] + w0;
    lane[3] = lane[3] + w1;
    mix_lanes();
    lane[0] = lane[0] + w2;
    lane[1] = lane[1] + w3;
  endtask

  task automatic advance_hash(logic [63:0] w_in, logic [3:0] bc_in, logic fin);
    logic [63:0] w;
    logic [63:0] tail [4];
    logic [63:0] t0;
    logic [63:0] t1;
    logic [7:0]  total;
    logic [4:0]  rem;
    int          k;
    int          nb;
    if (!in_msg) begin
      lane[0] = seed_reg;
      lane[1] = seed_reg;
      lane[2] = HASH_MAGIC;
      lane[3] = HASH_MAGIC;
      len_cnt = '0;
      in_msg  = 1'b1;
    end
    k = int'(len_cnt[4:3]);
    if (!fin) begin
      if (k == 3) absorb_block(pend[0], pend[1], pend[2], w_in);
      else pend[k] = w_in;
      len_cnt = len_cnt + 8'd8;
      return;
    end
    nb = (bc_in > 4'd8) ? 8 : int'(bc_in);
    w  = w_in;
    if (nb < 8) w = w & ((64'd1 << (8 * nb)) - 64'd1);
    total = len_cnt + 8'(nb);
    for (int i = 0; i < 4; i++) tail[i] = '0;
    if (k == 3 && nb == 8) begin
      absorb_block(pend[0], pend[1], pend[2], w);
    end else begin
      for (int i = 0; i < k; i++) tail[i] = pend[i];
      tail[k] = w;
    end
    rem = total[4:0];
    if (rem[4]) begin
      lane[2] = lane[2] + tail[0];
      lane[3] = lane[3] + tail[1];
      mix_lanes();
      t0 = tail[2];
      t1 = tail[3];
    end else begin
      t0 = tail[0];
      t1 = tail[1];
    end
    lane[3] = lane[3] + {total, 56'd0};
    if (rem[3:0] == 4'd0) begin
      lane[2] = lane[2] + HASH_MAGIC;
      lane[3] = lane[3] + HASH_MAGIC;
    end else begin
      lane[2] = lane[2] + t0;
      lane[3] = lane[3] + t1;
    end
    end_lanes();
    hash_q.push_back('{lo: lane[0], hi: lane[1]});
    in_msg  = 1'b0;
    len_cnt = '0;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [63:0] rand_data();
    int sel;
    sel = $urandom_range(99);
    if (sel < 3) return '0;
    if (sel < 6) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic int msg_len();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(7);
    if (sel < 95) return $urandom_range(16, 8);
    return $urandom_range(40, 30);
  endfunction

  task automatic push_word(word_t wd);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_word  <= wd.data;
    byte_count <= wd.nb;
    last       <= wd.fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_hash(wd.data, wd.nb, wd.fin);
    words_sent++;
  endtask

  task automatic send_message(int nfull);
    word_t wd;
    for (int i = 0; i < nfull; i++) begin
      wd.data = rand_data();
      wd.nb   = ($urandom_range(99) < 80) ? 4'd8 : 4'($urandom_range(15));
      wd.fin  = 1'b0;
      push_word(wd);
    end
    wd.data = rand_data();
    wd.nb   = ($urandom_range(99) < 70) ? 4'($urandom_range(8)) : 4'($urandom_range(15));
    wd.fin  = 1'b1;
    push_word(wd);
  endtask

  task automatic run_random(int nwords);
    int target;
    target = words_sent + nwords;
    while (words_sent < target) send_message(msg_len());
  endtask

  task automatic write_seed(logic [63:0] v);
    in_valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    seed_valid <= 1'b1;
    seed_data  <= v;
    @(posedge clk);
    while (!seed_ready) @(posedge clk);
    seed_valid <= 1'b0;
    seed_reg = v;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_seed('0);
    foreach (dir_tab[i]) push_word(dir_tab[i]);
    write_seed('1);
    hold_go = 1'b1;
    run_random(PHASE_WORDS);
    write_seed({$urandom, $urandom});
    steady = 1'b1;
    run_random(PHASE_WORDS);
    steady = 1'b0;
    write_seed(64'd1);
    run_random(PHASE_WORDS);
    write_seed({$urandom, $urandom});
    run_random(PHASE_WORDS);
    in_valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    digest_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (hash_q.size() == 0) begin
          report_mismatch("hash with none pending", hash_low, '0);
        end else begin
          want = hash_q.pop_front();
          if (hash_low !== want.lo) report_mismatch("hash_low", hash_low, want.lo);
          if (hash_high !== want.hi) report_mismatch("hash_high", hash_high, want.hi);
        end
      end
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (seed_valid && seed_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[filelist.f]
rtl/core/sh128_pkg.sv
rtl/core/sh128_front.sv
rtl/core/sh128_queue.sv
rtl/core/sh128_back.sv
rtl/core/short_hash128_stream_unit.sv
sim/tb_short_hash128_stream_unit.sv
